### src/grp_pkg.sv
package grp_pkg;

  // command codes of the input channel
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_CLEARED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // how the target space was obtained
  typedef enum logic [1:0] {
    MODE_FIT     = 2'd0,
    MODE_STRETCH = 2'd1,
    MODE_GROW    = 2'd2
  } mode_e;

  // sequencer states, one-hot
  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_RD     = 12'b000000000010,
    S_CHK    = 12'b000000000100,
    S_DECIDE = 12'b000000001000,
    S_PLAN   = 12'b000000010000,
    S_EVAL   = 12'b000000100000,
    S_SPLIT  = 12'b000001000000,
    S_RDLAST = 12'b000010000000,
    S_CPY    = 12'b000100000000,
    S_WR0    = 12'b001000000000,
    S_WR1    = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_e;

endpackage

### src/grp_ram.sv
module grp_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/guillotine_rect_packer.sv
// Guillotine rectangle packer for a growable atlas.
// Input channel (in_valid_i/in_ready_o) carries a command: insert a rectangle of
// rect_width_i x rect_height_i, or clear all free spaces and the used extent.
// Output channel (out_valid_o/out_ready_i) returns one result per command: the
// placement corner, the atlas extent after the command and a status code
// (placed, cleared, space table full, coordinate overflow).
// An insert scans the free-space table newest first, one entry at a time
// through the single registered read port of the space memory and one shared
// area multiplier, then plans, splits and writes back the chosen space.
// One command is in flight at a time; in_ready_o is high only while idle.
// The result sits in an output register; when the receiver stalls, the block
// finishes the next command and then waits with it until the register frees.
// Reset empties the table and zeroes the extent at once; the space memory
// needs no clearing pass since only entries below the fill count are read.
module guillotine_rect_packer #(
  parameter int MAX_SPACES = 64,
  parameter int COORD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [15:0] rect_width_i,
  input  logic [15:0] rect_height_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] place_left_o,
  output logic [15:0] place_top_o,
  output logic [15:0] atlas_width_o,
  output logic [15:0] atlas_height_o,
  output logic [1:0]  status_o
);
  import grp_pkg::*;

  localparam int AW   = $clog2(MAX_SPACES);
  localparam int CNTW = $clog2(MAX_SPACES + 1);
  localparam int CW   = COORD_BITS;
  localparam int SW   = ((CW > 16) ? CW : 16) + 1;
  localparam int EW   = 4 * CW;
  localparam logic [SW-1:0]   CMAX = {{(SW-CW){1'b0}}, {CW{1'b1}}};
  localparam logic [CNTW+1:0] MAXC = (CNTW+2)'(MAX_SPACES);

  typedef struct packed {
    logic [CW-1:0] left;
    logic [CW-1:0] top;
    logic [CW-1:0] w;
    logic [CW-1:0] h;
  } ent_t;

  state_e state_q, state_d;

  logic [15:0]     w_q, h_q;
  logic [CNTW-1:0] cnt_q, idx_q, cnt_new_q;
  logic [CW-1:0]   ew_q, eh_q, ew_new_q, eh_new_q;
  logic [2*CW-1:0] area_q, best_area_q;
  logic            pend_q, best_valid_q;
  logic [AW-1:0]   pidx_q, best_idx_q, tgt_idx_q;
  ent_t            pent_q, best_ent_q, sp_q, split0_q, split1_q;
  mode_e           mode_q;
  status_e         pre_st_q, st_q;
  logic [CW-1:0]   fw_q, fh_q;
  logic [1:0]      n_q;
  logic [CNTW:0]   base_q;

  logic            out_valid_q;
  logic [15:0]     pl_q, pt_q, aw_q, ah_q;
  status_e         ost_q;

  // memory port signals
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  ent_t            wdata, rdata;
  logic [EW-1:0]   rdata_raw;

  grp_ram #(
    .Width(EW),
    .Depth(MAX_SPACES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  assign rdata = ent_t'(rdata_raw);

  // widened request size
  logic [SW-1:0] wx, hx;
  assign wx = {{(SW-16){1'b0}}, w_q};
  assign hx = {{(SW-16){1'b0}}, h_q};

  function automatic logic [SW-1:0] ext(input logic [CW-1:0] v);
    return {{(SW-CW){1'b0}}, v};
  endfunction

  // fit test of the fetched entry
  logic fits;
  assign fits = (wx <= ext(rdata.w)) && (hx <= ext(rdata.h));

  // pending closest-candidate compare
  logic take_best;
  assign take_best = pend_q && (!best_valid_q || (area_q < best_area_q));

  // stretch decision on the smallest-area space
  logic signed [SW:0] dw, dh;
  logic               stretch;
  assign dw = $signed({1'b0, wx}) - $signed({1'b0, ext(best_ent_q.w)});
  assign dh = $signed({1'b0, hx}) - $signed({1'b0, ext(best_ent_q.h)});
  assign stretch = best_valid_q && (dw < $signed({1'b0, hx}))
                   && (dh < $signed({1'b0, wx}));

  // grow geometry
  logic          col;
  logic [SW-1:0] grow_sum, max_eh, max_ew;
  assign col      = (ew_q <= eh_q);
  assign grow_sum = col ? (ext(ew_q) + wx) : (ext(eh_q) + hx);
  assign max_eh   = (ext(eh_q) > hx) ? ext(eh_q) : hx;
  assign max_ew   = (ext(ew_q) > wx) ? ext(ew_q) : wx;

  // placement edges
  logic [SW-1:0] right_x, bottom_y;
  assign right_x  = ext(sp_q.left) + wx;
  assign bottom_y = ext(sp_q.top) + hx;

  // split count and table fill check
  logic [1:0]      n_c;
  logic [CNTW+1:0] fill_c;
  assign n_c    = {1'b0, fw_q != '0} + {1'b0, fh_q != '0};
  assign fill_c = {1'b0, base_q} + {{CNTW{1'b0}}, n_c};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (command_i == CMD_CLEAR) ? S_OUT : S_RD;
        end
      end
      S_RD:     state_d = (idx_q == '0) ? S_DECIDE : S_CHK;
      S_CHK:    state_d = fits ? S_EVAL : S_RD;
      S_DECIDE: state_d = pend_q ? S_DECIDE : S_PLAN;
      S_PLAN:   state_d = S_EVAL;
      S_EVAL: begin
        if (pre_st_q != ST_PLACED || right_x > CMAX || bottom_y > CMAX) begin
          state_d = S_OUT;
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (fill_c > MAXC) begin
          state_d = S_OUT;
        end else if (mode_q != MODE_GROW) begin
          state_d = S_RDLAST;
        end else begin
          state_d = (n_c != '0) ? S_WR0 : S_OUT;
        end
      end
      S_RDLAST: state_d = S_CPY;
      S_CPY:    state_d = (n_q != '0) ? S_WR0 : S_OUT;
      S_WR0:    state_d = (n_q == 2'd2) ? S_WR1 : S_OUT;
      S_WR1:    state_d = S_OUT;
      S_OUT:    state_d = (!out_valid_q || out_ready_i) ? S_IDLE : S_OUT;
      default:  state_d = S_IDLE;
    endcase
  end

  // memory access
  always_comb begin
    we    = 1'b0;
    waddr = tgt_idx_q;
    wdata = rdata;
    raddr = AW'(cnt_q - 1'b1);
    case (state_q)
      S_RD:  raddr = AW'(idx_q - 1'b1);
      S_CPY: we = 1'b1;
      S_WR0: begin
        we    = 1'b1;
        waddr = AW'(base_q);
        wdata = split0_q;
      end
      S_WR1: begin
        we    = 1'b1;
        waddr = AW'(base_q + 1'b1);
        wdata = split1_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      ew_q         <= '0;
      eh_q         <= '0;
      pend_q       <= 1'b0;
      best_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // result register fills on load, empties on transfer
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          pend_q       <= 1'b0;
          best_valid_q <= 1'b0;
        end
        S_RD, S_DECIDE: begin
          if (take_best) begin
            best_valid_q <= 1'b1;
          end
          pend_q <= 1'b0;
        end
        S_CHK: begin
          if (!fits) begin
            pend_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            if (st_q == ST_CLEARED) begin
              cnt_q <= '0;
              ew_q  <= '0;
              eh_q  <= '0;
            end else if (st_q == ST_PLACED) begin
              cnt_q <= cnt_new_q;
              ew_q  <= ew_new_q;
              eh_q  <= eh_new_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        w_q   <= rect_width_i;
        h_q   <= rect_height_i;
        idx_q <= cnt_q;
        st_q  <= (command_i == CMD_CLEAR) ? ST_CLEARED : ST_PLACED;
      end
      S_RD, S_DECIDE: begin
        if (take_best) begin
          best_area_q <= area_q;
          best_idx_q  <= pidx_q;
          best_ent_q  <= pent_q;
        end
      end
      S_CHK: begin
        // fetched entry: fit, or queue it for the area compare
        idx_q <= idx_q - 1'b1;
        if (fits) begin
          mode_q    <= MODE_FIT;
          sp_q      <= rdata;
          tgt_idx_q <= AW'(idx_q - 1'b1);
          pre_st_q  <= ST_PLACED;
        end else begin
          area_q <= rdata.w * rdata.h;
          pent_q <= rdata;
          pidx_q <= AW'(idx_q - 1'b1);
        end
      end
      S_PLAN: begin
        if (stretch) begin
          mode_q    <= MODE_STRETCH;
          tgt_idx_q <= best_idx_q;
          sp_q      <= '{left: best_ent_q.left, top: best_ent_q.top,
                         w: CW'(wx), h: CW'(hx)};
          pre_st_q  <= ST_PLACED;
        end else begin
          mode_q <= MODE_GROW;
          if (col) begin
            sp_q <= '{left: ew_q, top: '0, w: CW'(wx), h: CW'(max_eh)};
          end else begin
            sp_q <= '{left: '0, top: eh_q, w: CW'(max_ew), h: CW'(hx)};
          end
          if (grow_sum > CMAX) begin
            pre_st_q <= ST_OVERFLOW;
          end else if (cnt_q >= CNTW'(MAX_SPACES)) begin
            pre_st_q <= ST_FULL;
          end else begin
            pre_st_q <= ST_PLACED;
          end
        end
      end
      S_EVAL: begin
        fw_q     <= sp_q.w - CW'(wx);
        fh_q     <= sp_q.h - CW'(hx);
        ew_new_q <= (ext(ew_q) > right_x) ? ew_q : CW'(right_x);
        eh_new_q <= (ext(eh_q) > bottom_y) ? eh_q : CW'(bottom_y);
        base_q   <= (mode_q == MODE_GROW) ? {1'b0, cnt_q} : {1'b0, cnt_q} - 1'b1;
        if (pre_st_q != ST_PLACED) begin
          st_q <= pre_st_q;
        end else if (right_x > CMAX || bottom_y > CMAX) begin
          st_q <= ST_OVERFLOW;
        end
      end
      S_SPLIT: begin
        // leftover spaces, first the full-side piece of the larger leftover dimension
        n_q       <= n_c;
        cnt_new_q <= CNTW'(fill_c);
        if (fill_c > MAXC) begin
          st_q <= ST_FULL;
        end
        if (fw_q != '0 && (fh_q == '0 || fw_q > fh_q)) begin
          split0_q <= '{left: CW'(right_x), top: sp_q.top, w: fw_q, h: sp_q.h};
          split1_q <= '{left: sp_q.left, top: CW'(bottom_y), w: CW'(wx), h: fh_q};
        end else begin
          split0_q <= '{left: sp_q.left, top: CW'(bottom_y), w: sp_q.w, h: fh_q};
          split1_q <= '{left: CW'(right_x), top: sp_q.top, w: fw_q, h: CW'(hx)};
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          ost_q <= st_q;
          if (st_q == ST_PLACED) begin
            pl_q <= 16'(ext(sp_q.left));
            pt_q <= 16'(ext(sp_q.top));
            aw_q <= 16'(ext(ew_new_q));
            ah_q <= 16'(ext(eh_new_q));
          end else if (st_q == ST_CLEARED) begin
            pl_q <= '0;
            pt_q <= '0;
            aw_q <= '0;
            ah_q <= '0;
          end else begin
            pl_q <= '0;
            pt_q <= '0;
            aw_q <= 16'(ext(ew_q));
            ah_q <= 16'(ext(eh_q));
          end
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign place_left_o   = pl_q;
  assign place_top_o    = pt_q;
  assign atlas_width_o  = aw_q;
  assign atlas_height_o = ah_q;
  assign status_o       = ost_q;

endmodule

### tb/sv/tb_guillotine_rect_packer.sv
module tb_guillotine_rect_packer;
  import grp_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam longint unsigned COORD_TOP = 65535;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct {
    int unsigned left, top, w, h;
  } space_t;

  typedef struct {
    logic [15:0] left, top, aw, ah;
    status_e     st;
  } placement_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        command_i;
  logic [15:0] rect_width_i;
  logic [15:0] rect_height_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] place_left_o;
  logic [15:0] place_top_o;
  logic [15:0] atlas_width_o;
  logic [15:0] atlas_height_o;
  logic [1:0]  status_o;

  // packer state kept by the predictor
  space_t      spaces[TABLE_DEPTH];
  int unsigned n_spaces, ext_w, ext_h;
  // scratch copy for one insert
  space_t      wk[TABLE_DEPTH];
  int unsigned wk_n, wk_ew, wk_eh;

  placement_t  pending_q[$];
  int          errors;
  int          send_idle_pct, recv_stall_pct;
  int          hold_off;
  int unsigned quiet_cycles;

  guillotine_rect_packer dut (.*);

  // clock
  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  function automatic longint unsigned area_of(space_t s);
    return longint'(s.w) * longint'(s.h);
  endfunction

  // newest-first fit scan over the scratch table
  function automatic int find_fit(int unsigned w, int unsigned h, output int closest);
    closest = -1;
    for (int i = int'(wk_n) - 1; i >= 0; i--) begin
      if (closest < 0 || area_of(wk[i]) < area_of(wk[closest])) closest = i;
      if (w <= wk[i].w && h <= wk[i].h) return i;
    end
    return -1;
  endfunction

  // remove the chosen space, push its leftovers, report the corner
  function automatic status_e carve(int idx, int unsigned w, int unsigned h,
                                    output int unsigned pl, output int unsigned pt);
    space_t sp;
    space_t pieces[2];
    int n;
    int unsigned fw, fh;
    sp = wk[idx];
    n = 0;
    fw = sp.w - w;
    fh = sp.h - h;
    pl = 0;
    pt = 0;
    if (longint'(sp.left) + w > COORD_TOP || longint'(sp.top) + h > COORD_TOP)
      return ST_OVERFLOW;
    if (fw > 0 && fh == 0) begin
      pieces[0] = '{sp.left + w, sp.top, fw, sp.h}; n = 1;
    end else if (fw == 0 && fh > 0) begin
      pieces[0] = '{sp.left, sp.top + h, sp.w, fh}; n = 1;
    end else if (fw > 0 && fh > 0) begin
      if (fw > fh) begin
        pieces[0] = '{sp.left + w, sp.top, fw, sp.h};
        pieces[1] = '{sp.left, sp.top + h, w, fh};
      end else begin
        pieces[0] = '{sp.left, sp.top + h, sp.w, fh};
        pieces[1] = '{sp.left + w, sp.top, fw, h};
      end
      n = 2;
    end
    if (longint'(wk_n) - 1 + n > TABLE_DEPTH) return ST_FULL;
    wk[idx] = wk[wk_n - 1];
    wk_n--;
    for (int k = 0; k < n; k++) begin
      wk[wk_n] = pieces[k];
      wk_n++;
    end
    if (sp.left + w > wk_ew) wk_ew = sp.left + w;
    if (sp.top + h > wk_eh) wk_eh = sp.top + h;
    pl = sp.left;
    pt = sp.top;
    return ST_PLACED;
  endfunction

  // insert with stretch or growth on a miss
  function automatic status_e try_insert(int unsigned w, int unsigned h,
                                         output int unsigned pl, output int unsigned pt);
    int closest, idx;
    space_t ns;
    pl = 0;
    pt = 0;
    idx = find_fit(w, h, closest);
    if (idx < 0) begin
      if (closest >= 0 && (longint'(w) - longint'(wk[closest].w)) < longint'(h) &&
          (longint'(h) - longint'(wk[closest].h)) < longint'(w)) begin
        if (longint'(wk[closest].left) + w > COORD_TOP ||
            longint'(wk[closest].top) + h > COORD_TOP)
          return ST_OVERFLOW;
        wk[closest].w = w;
        wk[closest].h = h;
      end else begin
        if (wk_ew <= wk_eh) begin
          if (longint'(wk_ew) + w > COORD_TOP) return ST_OVERFLOW;
          ns = '{wk_ew, 0, w, (wk_eh > h) ? wk_eh : h};
        end else begin
          if (longint'(wk_eh) + h > COORD_TOP) return ST_OVERFLOW;
          ns = '{0, wk_eh, (wk_ew > w) ? wk_ew : w, h};
        end
        if (wk_n >= TABLE_DEPTH) return ST_FULL;
        wk[wk_n] = ns;
        wk_n++;
      end
      idx = find_fit(w, h, closest);
      if (idx < 0) return ST_FULL;
    end
    return carve(idx, w, h, pl, pt);
  endfunction

  // expected result of one accepted command, updating the predictor state
  function automatic placement_t predict_placement(logic cmd, logic [15:0] w, logic [15:0] h);
    placement_t r;
    int unsigned pl, pt;
    pl = 0;
    pt = 0;
    if (cmd == CMD_CLEAR) begin
      n_spaces = 0;
      ext_w = 0;
      ext_h = 0;
      r.st = ST_CLEARED;
    end else begin
      wk = spaces;
      wk_n = n_spaces;
      wk_ew = ext_w;
      wk_eh = ext_h;
      r.st = try_insert(w, h, pl, pt);
      if (r.st == ST_PLACED) begin
        spaces = wk;
        n_spaces = wk_n;
        ext_w = wk_ew;
        ext_h = wk_eh;
      end else begin
        pl = 0;
        pt = 0;
      end
    end
    r.left = pl[15:0];
    r.top = pt[15:0];
    r.aw = ext_w[15:0];
    r.ah = ext_h[15:0];
    return r;
  endfunction

  // offer one command and wait for its transfer
  task automatic send_cmd(logic cmd, logic [15:0] w, logic [15:0] h);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    rect_width_i <= w;
    rect_height_i <= h;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    pending_q.push_back(predict_placement(cmd, w, h));
    @(negedge clk_i);
  endtask

  task automatic insert_rect(int unsigned w, int unsigned h);
    send_cmd(CMD_INSERT, w[15:0], h[15:0]);
  endtask

  task automatic clear_all();
    send_cmd(CMD_CLEAR, 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  // receiver side: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    placement_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result transfer with no expectation pending");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (place_left_o !== e.left) begin
          $error("place_left exp %0d got %0d", e.left, place_left_o); errors++;
        end
        if (place_top_o !== e.top) begin
          $error("place_top exp %0d got %0d", e.top, place_top_o); errors++;
        end
        if (atlas_width_o !== e.aw) begin
          $error("atlas_width exp %0d got %0d", e.aw, atlas_width_o); errors++;
        end
        if (atlas_height_o !== e.ah) begin
          $error("atlas_height exp %0d got %0d", e.ah, atlas_height_o); errors++;
        end
        if (status_o !== e.st) begin
          $error("status exp %0d got %0d", e.st, status_o); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // field extremes, zero sizes, stretch, growth both ways, overflow
  task automatic test_directed();
    clear_all();
    insert_rect(1, 1);
    insert_rect(0, 5);
    insert_rect(7, 0);
    insert_rect(0, 0);
    insert_rect(30, 10);
    insert_rect(2, 3);
    insert_rect(31, 12);
    insert_rect(65535, 1);
    insert_rect(1, 65535);
    insert_rect(65535, 65535);
    clear_all();
    insert_rect(65535, 65535);
    insert_rect(1, 1);
    clear_all();
    insert_rect(40000, 100);
    insert_rect(40000, 100);
    insert_rect(100, 40000);
    insert_rect(100, 40000);
    insert_rect(16'hAAAA, 16'h5555);
    insert_rect(16'h5555, 16'hAAAA);
    clear_all();
    clear_all();
  endtask

  // many thin pieces to push the table to its limit
  task automatic test_table_full();
    clear_all();
    insert_rect(400, 400);
    for (int i = 0; i < 220; i++)
      insert_rect($urandom_range(1, 9), $urandom_range(1, 3));
    clear_all();
    for (int i = 0; i < 150; i++)
      insert_rect($urandom_range(1, 4), $urandom_range(1, 4) * 3);
  endtask

  // receiver holds off long while commands keep coming
  task automatic test_backpressure();
    hold_off = 2000;
    for (int i = 0; i < 12; i++) insert_rect($urandom_range(1, 20), $urandom_range(1, 20));
    drain();
  endtask

  // random mix of sizes with occasional random clears
  task automatic test_random(int count);
    int unsigned w, h, sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 3) begin
        clear_all();
      end else begin
        if (sel < 80) begin
          w = $urandom_range(0, 48);
          h = $urandom_range(0, 48);
        end else if (sel < 95) begin
          w = $urandom_range(0, 2000);
          h = $urandom_range(0, 2000);
        end else begin
          w = $urandom & 16'hFFFF;
          h = $urandom & 16'hFFFF;
        end
        insert_rect(w, h);
      end
    end
  endtask

  initial begin
    errors = 0;
    hold_off = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_spaces = 0;
    ext_w = 0;
    ext_h = 0;
    in_valid_i = 1'b0;
    command_i = CMD_INSERT;
    rect_width_i = '0;
    rect_height_i = '0;
    out_ready_i = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_table_full();
    test_backpressure();
    // idle phases: none, sender, receiver, both light
    test_random(300);
    send_idle_pct = 77;
    test_random(300);
    send_idle_pct = 0;
    recv_stall_pct = 77;
    test_random(300);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    test_random(300);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
